FILE: rtl/lach_pkg.sv
// ----------------------------------------------------------------------------
// lach_pkg
// Shared types, codes and constants of the load-average core hotplug block.
// ----------------------------------------------------------------------------
`default_nettype none

package lach_pkg;

  localparam int unsigned AVG_W         = 15;
  localparam int unsigned TASK_W        = 8;
  localparam int unsigned CFG_DATA_W    = 15;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned SAMPLE_SCALE  = 100;
  localparam int unsigned AVG_PER_SLOT  = 1000;
  localparam int unsigned ON_THR_RESET  = 400;
  localparam int unsigned OFF_THR_RESET = 200;
  localparam int unsigned RING_SIZE_DEF = 6;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_SUSPEND = 2'd1,
    OP_RESUME  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_ONLINE  = 2'd1,
    CMD_OFFLINE = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE  = 2'd0,
    REG_BOOST   = 2'd1,
    REG_ON_THR  = 2'd2,
    REG_OFF_THR = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [TASK_W-1:0] task_count;
    logic              core_online;
  } lach_in_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [AVG_W-1:0] average_load;
    logic [1:0]       next_interval;
    logic             sample_taken;
  } lach_out_t;

endpackage

`default_nettype wire

FILE: rtl/lach_div.sv
// ----------------------------------------------------------------------------
// lach_div
// Divider by a constant through multiplication with a rounded-up reciprocal,
// giving the exact quotient, which is registered after the dividend register.
// ----------------------------------------------------------------------------
`default_nettype none

module lach_div #(
  parameter int unsigned DVD_W   = 18,
  parameter int unsigned QUO_W   = 15,
  parameter int unsigned DIVISOR = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  output logic                  done_o,
  output logic [QUO_W-1:0]      quotient_o
);

  localparam int unsigned     SHIFT  = DVD_W + $clog2(DIVISOR);
  localparam int unsigned     MUL_W  = DVD_W + 1;
  localparam int unsigned     PROD_W = DVD_W + MUL_W;
  localparam longint unsigned RECIP  =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic [DVD_W-1:0]  dvd_q;
  logic [QUO_W-1:0]  quo_q;
  logic              busy_q;
  logic              done_q;
  logic [PROD_W-1:0] product;

  assign product = PROD_W'(dvd_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
    end
    if (busy_q) begin
      quo_q <= product[SHIFT +: QUO_W];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: rtl/load_average_core_hotplug_top.sv
// ----------------------------------------------------------------------------
// load_average_core_hotplug_top
// Hotplug governor for a second core, driven by a running load average.
// ----------------------------------------------------------------------------
// Suspend, resume and ignored items complete in the cycle they are accepted,
// with the result registered for the following cycle. A sample item that is
// acted on has its result registered after the accepting cycle, the ST_SUM
// state, which adds one ring entry per cycle through a single adder, and the
// ST_DIV state, in which the total is multiplied by the reciprocal of
// RING_SIZE + 1. A new item is taken only when the sequencer is idle and the
// result register is free or being read.
`default_nettype none

module load_average_core_hotplug_top #(
  parameter int unsigned RING_SIZE = lach_pkg::RING_SIZE_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [lach_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [lach_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire lach_pkg::lach_in_t                 in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output lach_pkg::lach_out_t                     out_data_o
);

  import lach_pkg::*;

  localparam int unsigned PW      = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
  localparam int unsigned TOT_W   = AVG_W + $clog2(RING_SIZE + 1);
  localparam int unsigned AVG_RST = (AVG_PER_SLOT * RING_SIZE) % (1 << AVG_W);

  state_e state_q, state_d;

  logic                 en_q;
  logic                 boost_q;
  logic [AVG_W-1:0]     on_thr_q;
  logic [AVG_W-1:0]     off_thr_q;
  logic [AVG_W-1:0]     ring_q [RING_SIZE];
  logic [PW-1:0]        pos_q;
  logic [AVG_W-1:0]     avg_q;
  logic                 susp_q;
  logic [TOT_W-1:0]     total_q, total_d;
  logic [PW-1:0]        idx_q;
  logic                 online_q;
  lach_out_t            out_q;
  logic                 out_valid_q;

  logic                 in_fire;
  logic                 out_free;
  logic                 sample_go;
  logic                 sum_last;
  logic                 sum_en;
  logic                 div_start;
  logic                 div_done;
  logic                 finish;
  logic [AVG_W-1:0]     quotient;
  logic [15:0]          scaled_full;
  logic [AVG_W-1:0]     scaled;
  logic [1:0]           imm_cmd;
  logic [1:0]           fin_cmd;
  logic                 susp_next;

  function automatic logic sum_last_pos(input logic [PW-1:0] p);
    return p == PW'(RING_SIZE - 1);
  endfunction

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign sample_go   = (in_data_i.operation == OP_SAMPLE) && en_q && !boost_q && !susp_q;
  assign sum_last    = idx_q == PW'(RING_SIZE - 1);
  assign total_d     = total_q + TOT_W'(ring_q[idx_q]);
  assign scaled_full = 16'(in_data_i.task_count) * 16'(SAMPLE_SCALE);
  assign scaled      = scaled_full[AVG_W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire && sample_go) state_d = ST_SUM;
      ST_SUM:  if (sum_last) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    sum_en     = 1'b0;
    div_start  = 1'b0;
    finish     = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = out_free;
      ST_SUM: begin
        sum_en    = 1'b1;
        div_start = sum_last;
      end
      ST_DIV:  finish = div_done;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_comb begin
    imm_cmd   = CMD_NONE;
    susp_next = susp_q;
    case (in_data_i.operation)
      OP_SUSPEND: begin
        if (!susp_q) begin
          susp_next = 1'b1;
          if (en_q && !boost_q && in_data_i.core_online) imm_cmd = CMD_OFFLINE;
        end
      end
      OP_RESUME: begin
        if (susp_q) begin
          susp_next = 1'b0;
          if (en_q && boost_q && !in_data_i.core_online) imm_cmd = CMD_ONLINE;
        end
      end
      default: imm_cmd = CMD_NONE;
    endcase
  end

  always_comb begin
    fin_cmd = CMD_NONE;
    if (quotient >= on_thr_q && !online_q) begin
      fin_cmd = CMD_ONLINE;
    end else if (quotient < off_thr_q && online_q) begin
      fin_cmd = CMD_OFFLINE;
    end
  end

  lach_div #(
    .DVD_W  (TOT_W),
    .QUO_W  (AVG_W),
    .DIVISOR(RING_SIZE + 1)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(total_d),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      en_q        <= 1'b1;
      boost_q     <= 1'b0;
      on_thr_q    <= AVG_W'(ON_THR_RESET);
      off_thr_q   <= AVG_W'(OFF_THR_RESET);
      ring_q      <= '{default: '0};
      pos_q       <= PW'(RING_SIZE - 1);
      avg_q       <= AVG_W'(AVG_RST);
      susp_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ENABLE:  en_q      <= cfg_wdata_i[0];
          REG_BOOST:   boost_q   <= cfg_wdata_i[0];
          REG_ON_THR:  on_thr_q  <= cfg_wdata_i[AVG_W-1:0];
          REG_OFF_THR: off_thr_q <= cfg_wdata_i[AVG_W-1:0];
          default:     en_q      <= en_q;
        endcase
      end
      if (in_fire) begin
        if (sample_go) begin
          ring_q[pos_q] <= scaled;
          pos_q <= sum_last_pos(pos_q) ? '0 : pos_q + PW'(1);
        end else begin
          susp_q <= susp_next;
        end
      end
      if (finish) begin
        avg_q <= quotient;
      end
      if (in_fire && !sample_go) begin
        out_valid_q <= 1'b1;
      end else if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      total_q  <= TOT_W'(avg_q);
      idx_q    <= '0;
      online_q <= in_data_i.core_online;
    end else if (sum_en) begin
      total_q <= total_d;
      idx_q   <= idx_q + PW'(1);
    end
    if (in_fire && !sample_go) begin
      out_q.command       <= imm_cmd;
      out_q.average_load  <= avg_q;
      out_q.next_interval <= in_data_i.core_online ? 2'd2 : 2'd1;
      out_q.sample_taken  <= 1'b0;
    end else if (finish) begin
      out_q.command       <= fin_cmd;
      out_q.average_load  <= quotient;
      out_q.next_interval <= online_q ? 2'd2 : 2'd1;
      out_q.sample_taken  <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE)
    else $error("input ready outside the idle state");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_out_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SUM |-> !out_valid_q)
    else $error("result register occupied while a sample is summed");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(RING_SIZE - 1))
    else $error("ring position out of range");

endmodule

`default_nettype wire

FILE: verif/lach_hotplug_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lach_hotplug_checker
// Watches both channels of the hotplug governor and the register port, keeps
// its own copy of the load ring, the running average and the suspend state,
// predicts the result of every accepted item and checks each result transfer
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lach_hotplug_checker #(
  parameter int unsigned RING_SIZE = lach_pkg::RING_SIZE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lach_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lach_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  lach_pkg::lach_in_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  lach_pkg::lach_out_t             out_data_i,
  output int                              mismatches_o,
  output int                              pending_o,
  output int                              checked_o
);

  import lach_pkg::*;

  lach_out_t        expected_results[$];
  logic [AVG_W-1:0] load_ring [RING_SIZE];
  int unsigned      ring_slot;
  logic [AVG_W-1:0] avg_load;
  logic             suspended;
  logic             cfg_enable;
  logic             cfg_boost;
  logic [AVG_W-1:0] online_thr;
  logic [AVG_W-1:0] offline_thr;
  int               mismatch_total;
  int               checked_total;

  function automatic lach_out_t predict_hotplug(input lach_in_t item);
    lach_out_t   res;
    int unsigned total;
    res               = '0;
    res.command       = CMD_NONE;
    res.next_interval = item.core_online ? 2'd2 : 2'd1;
    case (item.operation)
      OP_SAMPLE: begin
        if (cfg_enable && !cfg_boost && !suspended) begin
          load_ring[ring_slot] = AVG_W'(item.task_count * SAMPLE_SCALE);
          total = avg_load;
          for (int k = 0; k < RING_SIZE; k++) begin
            total += load_ring[k];
          end
          avg_load  = AVG_W'(total / (RING_SIZE + 1));
          ring_slot = (ring_slot + 1 >= RING_SIZE) ? 0 : ring_slot + 1;
          res.sample_taken = 1'b1;
          if (avg_load >= online_thr && !item.core_online) begin
            res.command = CMD_ONLINE;
          end else if (avg_load < offline_thr && item.core_online) begin
            res.command = CMD_OFFLINE;
          end
        end
      end
      OP_SUSPEND: begin
        if (!suspended) begin
          suspended = 1'b1;
          if (cfg_enable && !cfg_boost && item.core_online) begin
            res.command = CMD_OFFLINE;
          end
        end
      end
      OP_RESUME: begin
        if (suspended) begin
          suspended = 1'b0;
          if (cfg_enable && cfg_boost && !item.core_online) begin
            res.command = CMD_ONLINE;
          end
        end
      end
      default: begin
      end
    endcase
    res.average_load = avg_load;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatch_total++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    lach_out_t want;
    if (!rst_ni) begin
      foreach (load_ring[k]) begin
        load_ring[k] = '0;
      end
      ring_slot   = RING_SIZE - 1;
      avg_load    = AVG_W'(AVG_PER_SLOT * RING_SIZE);
      suspended   = 1'b0;
      cfg_enable  = 1'b1;
      cfg_boost   = 1'b0;
      online_thr  = AVG_W'(ON_THR_RESET);
      offline_thr = AVG_W'(OFF_THR_RESET);
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ENABLE:  cfg_enable  = cfg_wdata_i[0];
          REG_BOOST:   cfg_boost   = cfg_wdata_i[0];
          REG_ON_THR:  online_thr  = cfg_wdata_i;
          REG_OFF_THR: offline_thr = cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatch_total++;
          $display("%0t: result transfer with nothing expected, actual %h", $time,
                   out_data_i);
        end else begin
          want = expected_results.pop_front();
          checked_total++;
          check_field("command", 16'(want.command), 16'(out_data_i.command));
          check_field("average_load", 16'(want.average_load),
                      16'(out_data_i.average_load));
          check_field("next_interval", 16'(want.next_interval),
                      16'(out_data_i.next_interval));
          check_field("sample_taken", 16'(want.sample_taken),
                      16'(out_data_i.sample_taken));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(predict_hotplug(in_data_i));
      end
    end
    mismatches_o <= mismatch_total;
    pending_o    <= expected_results.size();
    checked_o    <= checked_total;
  end

endmodule

FILE: verif/tb_load_average_core_hotplug_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_load_average_core_hotplug_top
// Drives sample, suspend, resume and unused-code items into the hotplug
// governor in random bursts under a range of register settings, stalls the
// result side on its own pattern and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_load_average_core_hotplug_top;
  import lach_pkg::*;

  localparam int unsigned      RING_LEN        = RING_SIZE_DEF;
  localparam logic [1:0]       OP_UNUSED       = 2'd3;
  localparam logic [AVG_W-1:0] THR_MAX         = '1;
  localparam int               SETTLE_CYCLES   = 40;
  localparam int               IDLE_LIMIT      = 4000;
  localparam int               HOLD_CYCLES     = 300;
  localparam int               PHASES          = 8;
  localparam int               ITEMS_PER_PHASE = 250;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  lach_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  lach_out_t             out_data;

  int   mismatches;
  int   pending;
  int   checked;
  bit   hold_request;
  int   burst_left;
  logic core_up;
  int   sent_ops [4];
  int   cfg_settings;

  always #2 clk = ~clk;

  load_average_core_hotplug_top #(
    .RING_SIZE(RING_LEN)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  lach_hotplug_checker #(
    .RING_SIZE(RING_LEN)
  ) i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  function automatic lach_in_t make_item(input logic [1:0] op, input logic [7:0] tasks,
                                         input logic online);
    lach_in_t item;
    item.operation   = op;
    item.task_count  = tasks;
    item.core_online = online;
    return item;
  endfunction

  function automatic logic [AVG_W-1:0] random_threshold();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return '0;
    end else if (pick == 1) begin
      return THR_MAX;
    end
    return AVG_W'($urandom_range(0, 26000));
  endfunction

  function automatic lach_in_t random_item();
    int         pick;
    logic [1:0] op;
    logic [7:0] tasks;
    if ($urandom_range(0, 9) == 0) begin
      core_up = ~core_up;
    end
    pick = $urandom_range(0, 99);
    if (pick < 82) begin
      op = OP_SAMPLE;
    end else if (pick < 88) begin
      op = OP_SUSPEND;
    end else if (pick < 97) begin
      op = OP_RESUME;
    end else begin
      op = OP_UNUSED;
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      tasks = 8'($urandom_range(0, 8));
    end else if (pick < 8) begin
      tasks = 8'($urandom_range(0, 255));
    end else if (pick == 8) begin
      tasks = 8'd0;
    end else begin
      tasks = 8'd255;
    end
    return make_item(op, tasks, core_up);
  endfunction

  task automatic send_item(input lach_in_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent_ops[item.operation]++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic apply_config(input logic en, input logic boost,
                              input logic [AVG_W-1:0] on_thr,
                              input logic [AVG_W-1:0] off_thr);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_ENABLE;
    cfg_wdata <= CFG_DATA_W'(en);
    @(posedge clk);
    cfg_idx   <= REG_BOOST;
    cfg_wdata <= CFG_DATA_W'(boost);
    @(posedge clk);
    cfg_idx   <= REG_ON_THR;
    cfg_wdata <= on_thr;
    @(posedge clk);
    cfg_idx   <= REG_OFF_THR;
    cfg_wdata <= off_thr;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_settings++;
  endtask

  initial begin : receiver
    int hold_left;
    int mode;
    int mode_left;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 5) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    hold_request = 1'b0;
    burst_left   = 0;
    core_up      = 1'b0;
    cfg_settings = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Decay from the reset average, then suspend and resume edge cases.
    send_item(make_item(OP_SAMPLE, 8'd255, 1'b0));
    repeat (8) send_item(make_item(OP_SAMPLE, 8'd0, 1'b1));
    send_item(make_item(OP_UNUSED, 8'hA5, 1'b1));
    send_item(make_item(OP_SUSPEND, 8'd0, 1'b1));
    send_item(make_item(OP_SUSPEND, 8'd17, 1'b0));
    send_item(make_item(OP_SAMPLE, 8'd255, 1'b1));
    send_item(make_item(OP_RESUME, 8'd0, 1'b0));
    send_item(make_item(OP_RESUME, 8'd90, 1'b0));

    apply_config(1'b1, 1'b1, AVG_W'(ON_THR_RESET), AVG_W'(OFF_THR_RESET));
    send_item(make_item(OP_SAMPLE, 8'd255, 1'b0));
    send_item(make_item(OP_SUSPEND, 8'd0, 1'b1));
    send_item(make_item(OP_RESUME, 8'd0, 1'b0));

    apply_config(1'b0, 1'b0, AVG_W'(ON_THR_RESET), AVG_W'(OFF_THR_RESET));
    send_item(make_item(OP_SAMPLE, 8'd200, 1'b1));
    send_item(make_item(OP_SUSPEND, 8'd0, 1'b1));
    send_item(make_item(OP_RESUME, 8'd0, 1'b0));

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: apply_config(1'b1, 1'b0, AVG_W'(ON_THR_RESET), AVG_W'(OFF_THR_RESET));
        1: apply_config(1'b1, 1'b0, '0, THR_MAX);
        2: apply_config(1'b1, 1'b0, THR_MAX, '0);
        default: apply_config($urandom_range(0, 7) != 0, $urandom_range(0, 7) == 0,
                              random_threshold(), random_threshold());
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 2 && n == 40) begin
          hold_request = 1'b1;
        end
        if (phase == 3 && n == ITEMS_PER_PHASE / 2) begin
          drain_results();
        end
        send_item(random_item());
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run summary: %0d sample ticks, %0d suspends, %0d resumes, %0d unused codes sent",
             sent_ops[OP_SAMPLE], sent_ops[OP_SUSPEND], sent_ops[OP_RESUME],
             sent_ops[OP_UNUSED]);
    $display("Run summary: %0d results checked over %0d register settings, %0d mismatches",
             checked, cfg_settings, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lach_pkg.sv
rtl/lach_div.sv
rtl/load_average_core_hotplug_top.sv
verif/lach_hotplug_checker.sv
verif/tb_load_average_core_hotplug_top.sv
